// ===== sv/mhe_pkg.sv =====
// ----------------------------------------------------------------------------
// mhe_pkg
// Shared types and constants for the masked histogram equaliser.
// ----------------------------------------------------------------------------
`default_nettype none
package mhe_pkg;

  localparam int GreyLevels = 256;
  localparam int BinW       = $clog2(GreyLevels);
  localparam int MaxDim     = 4096;
  localparam int CountW     = 25;
  localparam int DimW       = 13;
  localparam int CoordW     = 12;
  localparam int RadW       = 11;
  localparam int CfgW       = 13;
  localparam int NumW       = CountW + 8;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam logic [DimW-1:0]   DimLimit = DimW'(MaxDim);

  typedef enum logic [1:0] {
    CMD_COUNT = 2'd0,
    CMD_MAP   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_RADIUS = 2'd2,
    REG_MASK   = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COUNT,
    S_BUILD,
    S_MAP_RD,
    S_MUL,
    S_DIV,
    S_OUT
  } state_t;

  function automatic logic [CountW-1:0] sat_add(input logic [CountW-1:0] a,
                                                input logic [CountW-1:0] b);
    logic [CountW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CountW] ? CountMax : s[CountW-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== sv/masked_histogram_equalizer.sv =====
// ----------------------------------------------------------------------------
// masked_histogram_equalizer
// Two-pass 8-bit histogram equaliser over a stream of positioned pixels.
// ----------------------------------------------------------------------------
// Sequence: a used count runs S_COUNT then S_OUT; other counts, clears and
//   pass-through go straight to S_OUT; a map runs S_MAP_RD, S_MUL, S_DIV
//   (skipped when the pixel is unused or the total is zero) and S_OUT, with
//   a sweep (S_BUILD) ahead of it on the first map after the histogram changed.
// Throughput: one transaction at a time; in_stall is high outside S_IDLE,
//   and the quotient unit takes 8 steps.
// Reset: synchronous, active high; bins read as zero via per-bin valid flags,
//   total and the cumulative-ready flag clear, registers take default values.
`default_nettype none
module masked_histogram_equalizer
  import mhe_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [CfgW-1:0]   cfg_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        cmd,
  input  wire logic [7:0]        pixel,
  input  wire logic              mask_bit,
  input  wire logic [CoordW-1:0] row,
  input  wire logic [CoordW-1:0] col,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             out_pixel,
  output logic                   touched
);

  // Configuration registers
  logic [DimW-1:0] image_width, image_height;
  logic [RadW-1:0] border_radius;
  logic            use_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= DimW'(640);
      image_height  <= DimW'(480);
      border_radius <= '0;
      use_mask      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WIDTH:  image_width   <= cfg_data[DimW-1:0];
        REG_HEIGHT: image_height  <= cfg_data[DimW-1:0];
        REG_RADIUS: border_radius <= cfg_data[RadW-1:0];
        REG_MASK:   use_mask      <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  // Interior and mask test on the incoming transaction
  logic [DimW-1:0] w_eff, h_eff;
  logic            used_in;
  assign w_eff = (image_width  > DimLimit) ? DimLimit : image_width;
  assign h_eff = (image_height > DimLimit) ? DimLimit : image_height;
  always_comb begin
    used_in = ({2'b0, row} >= {3'b0, border_radius})
           && ({2'b0, row} + {3'b0, border_radius} < {1'b0, h_eff})
           && ({2'b0, col} >= {3'b0, border_radius})
           && ({2'b0, col} + {3'b0, border_radius} < {1'b0, w_eff})
           && (!use_mask || mask_bit);
  end

  // Control state
  state_t              state, state_next;
  cmd_t                cmd_r;
  logic [7:0]          pix_r;
  logic                used_r;
  logic [CountW-1:0]   total;
  logic                cum_ready;
  logic [BinW:0]       sweep_idx;
  logic                sweep_pend;
  logic [BinW-1:0]     sweep_wr;
  logic [CountW-1:0]   run;
  logic [NumW-1:0]     num;
  logic [2:0]          bitk;
  logic [7:0]          quo;
  logic [7:0]          res_r;
  logic                touch_r;

  logic                accept;
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);

  // Bin memory with per-bin valid flags; an invalid bin reads as zero
  logic [CountW-1:0]   bin_mem [GreyLevels];
  logic [GreyLevels-1:0] bin_vld;
  logic [BinW-1:0]     bin_raddr;
  logic [CountW-1:0]   bin_q;
  logic                bin_qv;
  logic [CountW-1:0]   bin_val;
  logic                bin_we;
  logic [BinW-1:0]     bin_waddr;
  logic [CountW-1:0]   bin_wdata;

  assign bin_raddr = (state == S_BUILD) ? sweep_idx[BinW-1:0] : pixel;
  assign bin_val   = bin_qv ? bin_q : '0;
  assign bin_we    = (state == S_COUNT);
  assign bin_waddr = pix_r;
  assign bin_wdata = sat_add(bin_val, CountW'(1));

  always_ff @(posedge clk) begin
    bin_q <= bin_mem[bin_raddr];
    if (bin_we) begin
      bin_mem[bin_waddr] <= bin_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_vld <= '0;
      bin_qv  <= 1'b0;
    end else begin
      bin_qv <= bin_vld[bin_raddr];
      if (accept && cmd_t'(cmd) == CMD_CLEAR) begin
        bin_vld <= '0;
      end else if (bin_we) begin
        bin_vld[bin_waddr] <= 1'b1;
      end
    end
  end

  // Cumulative memory; rebuilt by the sweep before a map reads it after the histogram changed
  logic [CountW-1:0] cum_mem [GreyLevels];
  logic [CountW-1:0] cum_q;
  logic [CountW-1:0] run_new;
  assign run_new = sat_add(run, bin_val);

  always_ff @(posedge clk) begin
    cum_q <= cum_mem[pix_r];
    if (state == S_BUILD && sweep_pend) begin
      cum_mem[sweep_wr] <= run_new;
    end
  end

  // Quotient step: subtract total shifted by the current bit when it fits
  logic [NumW:0] trial;
  assign trial = {1'b0, num} - ({{(NumW+1-CountW){1'b0}}, total} << bitk);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_t'(cmd))
            CMD_COUNT: state_next = used_in ? S_COUNT : S_OUT;
            CMD_MAP:   state_next = cum_ready ? S_MAP_RD : S_BUILD;
            default:   state_next = S_OUT;
          endcase
        end
      end
      S_COUNT:  state_next = S_OUT;
      S_BUILD:  if (sweep_pend && sweep_wr == BinW'(GreyLevels - 1)) state_next = S_MAP_RD;
      S_MAP_RD: state_next = S_MUL;
      S_MUL:    state_next = (used_r && total != '0) ? S_DIV : S_OUT;
      S_DIV:    if (bitk == 3'd0) state_next = S_OUT;
      S_OUT:    if (!out_valid || !out_stall) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      total      <= '0;
      cum_ready  <= 1'b0;
      sweep_pend <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      // hold result until the receiver takes it
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          sweep_pend <= 1'b0;
          if (accept && cmd_t'(cmd) == CMD_CLEAR) begin
            total     <= '0;
            cum_ready <= 1'b0;
          end
        end
        S_COUNT: begin
          total     <= sat_add(total, CountW'(1));
          cum_ready <= 1'b0;
        end
        S_BUILD: begin
          sweep_pend <= !sweep_idx[BinW];
          if (sweep_pend && sweep_wr == BinW'(GreyLevels - 1)) begin
            cum_ready <= 1'b1;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload and datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r     <= cmd_t'(cmd);
      pix_r     <= pixel;
      used_r    <= used_in;
      res_r     <= pixel;
      touch_r   <= (cmd_t'(cmd) == CMD_COUNT) && used_in;
      sweep_idx <= '0;
      run       <= '0;
    end
    if (state == S_BUILD) begin
      if (!sweep_idx[BinW]) begin
        sweep_idx <= sweep_idx + 1'b1;
      end
      sweep_wr <= sweep_idx[BinW-1:0];
      if (sweep_pend) begin
        run <= run_new;
      end
    end
    if (state == S_MUL) begin
      // advance 255 * cdf as a shift and subtract
      num  <= ({{(NumW-CountW){1'b0}}, cum_q} << 8) - {{(NumW-CountW){1'b0}}, cum_q};
      bitk <= 3'd7;
      quo  <= '0;
    end
    if (state == S_DIV) begin
      if (!trial[NumW]) begin
        num       <= trial[NumW-1:0];
        quo[bitk] <= 1'b1;
      end
      bitk <= bitk - 3'd1;
      if (bitk == 3'd0) begin
        res_r   <= trial[NumW] ? quo : (quo | 8'd1);
        touch_r <= 1'b1;
      end
    end
    if (state == S_OUT && (!out_valid || !out_stall)) begin
      out_pixel <= res_r;
      touched   <= touch_r;
    end
  end

  // Checks
  a_div_total: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> total != '0) else $error("divide with empty total");
  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE) else $error("transaction dropped");
  a_ready_src: assert property (@(posedge clk) disable iff (rst)
    $rose(cum_ready) |-> $past(state) == S_BUILD) else $error("cdf ready without sweep");
  a_map_cmd: assert property (@(posedge clk) disable iff (rst)
    state == S_BUILD |-> cmd_r == CMD_MAP) else $error("sweep outside map");

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the masked histogram equaliser: a local model of
// the bins, cumulative table and border/mask test predicts every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
  import mhe_pkg::*;

  localparam int WatchLimit = 20000;
  localparam int Drain      = 400;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [CfgW-1:0]   cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        cmd;
  logic [7:0]        pixel;
  logic              mask_bit;
  logic [CoordW-1:0] row;
  logic [CoordW-1:0] col;
  logic              out_valid;
  logic              out_stall;
  logic [7:0]        out_pixel;
  logic              touched;

  masked_histogram_equalizer DUT (.*);

  typedef struct packed {
    logic [7:0] level;
    logic       hit;
  } eq_result_t;

  // Model state
  logic [12:0]       m_width, m_height;
  logic [10:0]       m_radius;
  logic              m_use_mask;
  logic [CountW-1:0] m_bins [GreyLevels];
  logic [CountW-1:0] m_cdf  [GreyLevels];
  logic [CountW-1:0] m_total;
  logic              m_cdf_ok;

  eq_result_t pending_results[$];
  bit         failed;
  bit         hold_off;
  int         idle_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [CountW-1:0] add_sat(logic [CountW-1:0] a, logic [CountW-1:0] b);
    logic [CountW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CountW] ? {CountW{1'b1}} : s[CountW-1:0];
  endfunction

  function automatic eq_result_t predict_pixel(cmd_t c, logic [7:0] p, logic m,
                                               logic [11:0] r, logic [11:0] cc);
    eq_result_t res;
    longint w, h, rad, q;
    logic [CountW-1:0] run;
    bit used;
    w   = (m_width > 4096) ? 4096 : m_width;
    h   = (m_height > 4096) ? 4096 : m_height;
    rad = m_radius;
    used = (longint'(r) >= rad) && (longint'(r) < h - rad) &&
           (longint'(cc) >= rad) && (longint'(cc) < w - rad) &&
           (!m_use_mask || m);
    res.level = p;
    res.hit   = 1'b0;
    case (c)
      CMD_COUNT: begin
        if (used) begin
          m_bins[p] = add_sat(m_bins[p], CountW'(1));
          m_total   = add_sat(m_total, CountW'(1));
          m_cdf_ok  = 1'b0;
          res.hit   = 1'b1;
        end
      end
      CMD_MAP: begin
        if (!m_cdf_ok) begin
          run = '0;
          for (int i = 0; i < GreyLevels; i++) begin
            run = add_sat(run, m_bins[i]);
            m_cdf[i] = run;
          end
          m_cdf_ok = 1'b1;
        end
        if (used && m_total != 0) begin
          q = (255 * longint'(m_cdf[p])) / longint'(m_total);
          res.level = (q > 255) ? 8'd255 : q[7:0];
          res.hit   = 1'b1;
        end
      end
      CMD_CLEAR: begin
        foreach (m_bins[i]) m_bins[i] = '0;
        m_total  = '0;
        m_cdf_ok = 1'b0;
      end
      default: ;
    endcase
    return res;
  endfunction

  // Mostly short gaps, a few long ones, and often none at all
  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Valid stays up after acceptance so that a transaction with no gap follows
  // at once; a gap or a drain drops it
  task automatic send_pixel(cmd_t c, logic [7:0] p, logic m, logic [11:0] r, logic [11:0] cc);
    int g;
    eq_result_t exp_res;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    pixel    <= p;
    mask_bit <= m;
    row      <= r;
    col      <= cc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    exp_res = predict_pixel(c, p, m, r, cc);
    pending_results = {pending_results, exp_res};
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CfgW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_WIDTH:  m_width    = val;
      REG_HEIGHT: m_height   = val;
      REG_RADIUS: m_radius   = val[10:0];
      REG_MASK:   m_use_mask = val[0];
      default: ;
    endcase
  endtask

  // Wait until every expected result is back, then let the pipeline settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (Drain) @(posedge clk);
  endtask

  task automatic set_geometry(logic [12:0] w, logic [12:0] h, logic [10:0] rad, logic um);
    drain_results();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_RADIUS, CfgW'(rad));
    write_reg(REG_MASK, CfgW'(um));
    cfg_we <= 1'b0;
  endtask

  task automatic send_random(int n, int count_bias);
    cmd_t c;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < count_bias)      c = CMD_COUNT;
      else if (k < 96)         c = CMD_MAP;
      else if (k < 98)         c = CMD_CLEAR;
      else                     c = CMD_NONE;
      send_pixel(c, 8'($urandom), 1'($urandom),
                 ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 40)),
                 ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 40)));
    end
  endtask

  task automatic test_directed();
    set_geometry(13'd32, 13'd32, 11'd2, 1'b1);
    send_pixel(CMD_MAP,   8'd7,   1'b1, 12'd5, 12'd5);     // histogram from the earlier random run
    send_pixel(CMD_COUNT, 8'd0,   1'b1, 12'd2, 12'd2);     // first inside corner
    send_pixel(CMD_COUNT, 8'd255, 1'b1, 12'd29, 12'd29);   // last inside corner
    send_pixel(CMD_COUNT, 8'd128, 1'b0, 12'd10, 12'd10);   // masked off
    send_pixel(CMD_COUNT, 8'd9,   1'b1, 12'd1, 12'd10);    // in the border
    send_pixel(CMD_COUNT, 8'd9,   1'b1, 12'd10, 12'd30);   // border, right side
    send_pixel(CMD_COUNT, 8'd9,   1'b1, 12'hFFF, 12'hFFF); // far outside
    send_pixel(CMD_MAP,   8'd0,   1'b1, 12'd5, 12'd5);     // builds cumulative table
    send_pixel(CMD_MAP,   8'd255, 1'b1, 12'd5, 12'd5);     // top bin maps to 255
    send_pixel(CMD_MAP,   8'd100, 1'b0, 12'd5, 12'd5);     // masked map
    send_pixel(CMD_NONE,  8'd55,  1'b1, 12'd5, 12'd5);     // unknown command
    send_pixel(CMD_CLEAR, 8'd66,  1'b1, 12'd5, 12'd5);
    send_pixel(CMD_MAP,   8'd66,  1'b1, 12'd5, 12'd5);     // cleared: pass-through
    set_geometry(13'd1, 13'd1, 11'd0, 1'b0);               // smallest image
    send_pixel(CMD_COUNT, 8'd3,   1'b0, 12'd0, 12'd0);
    send_pixel(CMD_COUNT, 8'd3,   1'b0, 12'd0, 12'd1);
    send_pixel(CMD_MAP,   8'd3,   1'b0, 12'd0, 12'd0);
    set_geometry(13'd100, 13'd100, 11'd2047, 1'b0);        // no interior left
    send_pixel(CMD_COUNT, 8'd1,   1'b1, 12'd2047, 12'd2047);
    send_pixel(CMD_MAP,   8'd1,   1'b1, 12'd2048, 12'd2048);
    set_geometry(13'd8191, 13'd4096, 11'd0, 1'b0);         // oversize clamps to 4096
    send_pixel(CMD_COUNT, 8'd200, 1'b1, 12'hFFF, 12'hFFF);
    send_pixel(CMD_MAP,   8'd200, 1'b1, 12'hFFF, 12'hFFF);
    send_pixel(CMD_CLEAR, 8'd0,   1'b0, 12'd0, 12'd0);
  endtask

  // Two-pass frames: a mostly-count pass then a mostly-map pass over the same geometry
  task automatic test_frames();
    for (int f = 0; f < 8; f++) begin
      set_geometry(13'($urandom_range(16, 48)), 13'($urandom_range(16, 48)),
                   11'($urandom_range(0, 4)), 1'($urandom));
      send_pixel(CMD_CLEAR, 8'($urandom), 1'b1, 12'd0, 12'd0);
      send_random(80, 90);
      send_random(80, 5);
    end
  endtask

  // Receiver stalls for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    set_geometry(13'd640, 13'd480, 11'd0, 1'b0);
    hold_off = 1'b1;
    send_random(30, 50);
    drain_results();
  endtask

  task automatic test_random_mix();
    set_geometry(13'd4096, 13'd4096, 11'd0, 1'b0);
    send_random(200, 60);
    set_geometry(13'd40, 13'd40, 11'd0, 1'b1);
    send_random(200, 50);
  endtask

  // Result checker and receiver stall control
  always @(posedge clk) begin
    eq_result_t exp_res;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: out_pixel %0d touched %0b", out_pixel, touched);
        failed = 1'b1;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_pixel !== exp_res.level) begin
          $error("out_pixel: expected %0d, got %0d", exp_res.level, out_pixel);
          failed = 1'b1;
        end
        if (touched !== exp_res.hit) begin
          $error("touched: expected %0b, got %0b", exp_res.hit, touched);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin : stall_gen
    int g;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      g = gap_len();
      if (g > 0) begin
        out_stall <= 1'b1;
        repeat (g) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Watchdog: count cycles with no transaction on either side and no register write
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    failed      = 1'b0;
    hold_off    = 1'b0;
    idle_cycles = 0;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = REG_WIDTH;
    cfg_data  = '0;
    in_valid  = 1'b0;
    cmd       = CMD_NONE;
    pixel     = '0;
    mask_bit  = 1'b0;
    row       = '0;
    col       = '0;
    m_width = 13'd640; m_height = 13'd480; m_radius = '0; m_use_mask = 1'b0;
    foreach (m_bins[i]) begin
      m_bins[i] = '0;
      m_cdf[i]  = '0;
    end
    m_total  = '0;
    m_cdf_ok = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_random(10, 50);  // runs on the reset-time register values
    test_directed();
    test_frames();
    test_backpressure();
    test_random_mix();
    drain_results();
    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ===== masked_histogram_equalizer.f =====
sv/mhe_pkg.sv
sv/masked_histogram_equalizer.sv
tb/sv/tb.sv
